// ----- hdl/bft_pkg.sv -----
// Shared types and constants of the two-hash Bloom filter.
`timescale 1ns / 1ps

package bft_pkg;

   localparam int HASH_W = 32;

   localparam logic [HASH_W-1:0] SEED_FIRST  = 32'd17;
   localparam logic [HASH_W-1:0] SEED_SECOND = 32'd31;
   localparam logic [HASH_W-1:0] HASH_MULT   = 32'd101;

   // operation codes
   localparam logic OP_ADD   = 1'b0;
   localparam logic OP_CHECK = 1'b1;

   typedef struct packed {
      logic       operation;
      logic [7:0] data_byte;
      logic       byte_valid;
      logic       last;
   } req_type;

   typedef struct packed {
      logic done_operation;
      logic possibly_present;
   } rsp_type;

endpackage

// ----- hdl/bft_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module bft_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 1000
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hdl/bft_mod_unit.sv -----
// Reduction of a 32-bit hash modulo the filter size by reciprocal multiplication.
`timescale 1ns / 1ps

module bft_mod_unit #(
   parameter int FILTER_BITS = 1000
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           load,
   input  logic [bft_pkg::HASH_W-1:0]     value,
   output logic                           done,
   output logic [$clog2(FILTER_BITS)-1:0] remainder
);

   import bft_pkg::*;

   localparam int RW    = $clog2(FILTER_BITS);
   localparam int SHIFT = 31 + RW;
   // floor(2^SHIFT / FILTER_BITS) fits in 32 bits; the quotient estimate is
   // exact or one short, so a single compare and subtract finishes the job
   localparam logic [63:0]       RECIP_W = (64'd1 << SHIFT) / 64'(FILTER_BITS);
   localparam logic [HASH_W-1:0] RECIP   = RECIP_W[HASH_W-1:0];
   localparam logic [HASH_W-1:0] MOD_VAL = HASH_W'(FILTER_BITS);
   // load -> product -> difference -> corrected remainder
   localparam logic [1:0]        STEPS   = 2'd3;

   logic [HASH_W-1:0] val_ff, val_in;
   logic [63:0]       prod_ff, prod_in;
   logic [HASH_W-1:0] diff_ff, diff_in;
   logic [RW-1:0]     rem_ff, rem_in;
   logic [1:0]        cnt_ff, cnt_in;
   logic [HASH_W-1:0] quot;
   logic [HASH_W-1:0] rem_wide;

   always_comb begin
      quot     = HASH_W'(prod_ff >> SHIFT);
      rem_wide = (diff_ff >= MOD_VAL) ? (diff_ff - MOD_VAL) : diff_ff;
      val_in   = load ? value : val_ff;
      prod_in  = 64'(val_ff) * 64'(RECIP);
      diff_in  = val_ff - quot * MOD_VAL;
      rem_in   = rem_wide[RW-1:0];
      cnt_in   = cnt_ff;
      if (load) begin
         cnt_in = STEPS;
      end else if (cnt_ff != '0) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      val_ff  <= val_in;
      prod_ff <= prod_in;
      diff_ff <= diff_in;
      rem_ff  <= rem_in;
   end

   assign done      = (cnt_ff == '0);
   assign remainder = rem_ff;

endmodule

// ----- hdl/bloom_filter_two_hash.sv -----
// Top level of the two-hash Bloom filter fed one element byte per beat.
// Non-last beats: hashed in the accept cycle, busy stays low, one beat per cycle.
// Last beat: modulo reduction by reciprocal multiply (S_MOD), then bitmap writes in S_WR1
//   and S_WR2 (add) or bitmap reads in S_RD1 and S_RD2, compared in S_CHK (check); busy is
//   low again in the cycle in which rsp_strobe rises.
// Reset: clears the bitmap RAM one bit per cycle, with busy high until it is done.
// The receiver cannot stall: each result is a one-cycle strobe.
`timescale 1ns / 1ps

module bloom_filter_two_hash #(
   parameter int FILTER_BITS = 1000
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  bft_pkg::req_type req_data,
   output logic             rsp_strobe,
   output bft_pkg::rsp_type rsp_data
);

   import bft_pkg::*;

   localparam int AW = $clog2(FILTER_BITS);
   localparam int LAST_I = FILTER_BITS - 1;
   localparam logic [AW-1:0] LAST_ADDR = LAST_I[AW-1:0];

   // sequencer states
   localparam logic [2:0] S_CLEAR = 3'd0;
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_MOD   = 3'd2;
   localparam logic [2:0] S_WR1   = 3'd3;
   localparam logic [2:0] S_WR2   = 3'd4;
   localparam logic [2:0] S_RD1   = 3'd5;
   localparam logic [2:0] S_RD2   = 3'd6;
   localparam logic [2:0] S_CHK   = 3'd7;

   logic [2:0]        state_ff, state_in;
   logic [HASH_W-1:0] hash1_ff, hash1_in;
   logic [HASH_W-1:0] hash2_ff, hash2_in;
   logic              ended_ff, ended_in;
   logic [AW-1:0]     clr_ff, clr_in;
   logic              op_ff, op_in;
   logic              bit1_ff, bit1_in;
   logic              rsp_strobe_ff, rsp_strobe_in;
   rsp_type           rsp_ff, rsp_in;

   // next hashes for the beat on the request port
   logic [HASH_W-1:0] byte_ext;
   logic [HASH_W-1:0] next_hash1, next_hash2;
   logic              next_ended;

   logic              mod_load;
   logic              mod_done1, mod_done2;
   logic [AW-1:0]     idx1, idx2;

   logic              wr_en;
   logic [AW-1:0]     wr_addr;
   logic              wr_data;
   logic [AW-1:0]     rd_addr;
   logic              rd_data;

   assign byte_ext = {{(HASH_W-8){req_data.data_byte[7]}}, req_data.data_byte};

   // hashing stops at the first zero byte of an element
   always_comb begin
      next_hash1 = hash1_ff;
      next_hash2 = hash2_ff;
      next_ended = ended_ff;
      if (req_data.byte_valid && !ended_ff) begin
         if (req_data.data_byte == 8'd0) begin
            next_ended = 1'b1;
         end else begin
            next_hash1 = hash1_ff * HASH_MULT + byte_ext;
            next_hash2 = hash2_ff * HASH_MULT + byte_ext;
         end
      end
   end

   always_comb begin
      state_in      = state_ff;
      hash1_in      = hash1_ff;
      hash2_in      = hash2_ff;
      ended_in      = ended_ff;
      clr_in        = clr_ff;
      op_in         = op_ff;
      bit1_in       = bit1_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = rsp_ff;
      mod_load      = 1'b0;
      wr_en         = 1'b0;
      wr_addr       = idx1;
      rd_addr       = idx1;
      unique case (state_ff)
         S_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            if (clr_ff == LAST_ADDR) begin
               state_in = S_IDLE;
            end else begin
               clr_in = clr_ff + 1'b1;
            end
         end
         S_IDLE: begin
            if (start) begin
               if (req_data.last) begin
                  // element complete: reduce the final hashes, reload seeds
                  mod_load = 1'b1;
                  op_in    = req_data.operation;
                  hash1_in = SEED_FIRST;
                  hash2_in = SEED_SECOND;
                  ended_in = 1'b0;
                  state_in = S_MOD;
               end else begin
                  hash1_in = next_hash1;
                  hash2_in = next_hash2;
                  ended_in = next_ended;
               end
            end
         end
         S_MOD: begin
            if (mod_done1 && mod_done2) begin
               state_in = (op_ff == OP_ADD) ? S_WR1 : S_RD1;
            end
         end
         S_WR1: begin
            wr_en    = 1'b1;
            wr_addr  = idx1;
            state_in = S_WR2;
         end
         S_WR2: begin
            wr_en                   = 1'b1;
            wr_addr                 = idx2;
            rsp_strobe_in           = 1'b1;
            rsp_in.done_operation   = OP_ADD;
            rsp_in.possibly_present = 1'b0;
            state_in                = S_IDLE;
         end
         S_RD1: begin
            rd_addr  = idx1;
            state_in = S_RD2;
         end
         S_RD2: begin
            rd_addr  = idx2;
            bit1_in  = rd_data;
            state_in = S_CHK;
         end
         S_CHK: begin
            rsp_strobe_in           = 1'b1;
            rsp_in.done_operation   = OP_CHECK;
            rsp_in.possibly_present = bit1_ff & rd_data;
            state_in                = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // zeros during the clearing pass, ones for adds
   assign wr_data = (state_ff != S_CLEAR);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         hash1_ff      <= SEED_FIRST;
         hash2_ff      <= SEED_SECOND;
         ended_ff      <= 1'b0;
         clr_ff        <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         hash1_ff      <= hash1_in;
         hash2_ff      <= hash2_in;
         ended_ff      <= ended_in;
         clr_ff        <= clr_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      op_ff   <= op_in;
      bit1_ff <= bit1_in;
      rsp_ff  <= rsp_in;
   end

   bft_mod_unit #(
      .FILTER_BITS(FILTER_BITS)
   ) u_mod_first (
      .clock    (clock),
      .reset    (reset),
      .load     (mod_load),
      .value    (next_hash1),
      .done     (mod_done1),
      .remainder(idx1)
   );

   bft_mod_unit #(
      .FILTER_BITS(FILTER_BITS)
   ) u_mod_second (
      .clock    (clock),
      .reset    (reset),
      .load     (mod_load),
      .value    (next_hash2),
      .done     (mod_done2),
      .remainder(idx2)
   );

   // one bit per entry; busy covers every access, so no two overlap
   bft_ram #(
      .WIDTH(1),
      .DEPTH(FILTER_BITS)
   ) u_bitmap (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   assign busy       = (state_ff != S_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

`ifndef NO_ASSERTIONS
   // a result beat only closes an element the sequencer was working on
   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(busy))
      else $error("result beat without a preceding busy cycle");

   // one result per element: never two strobes in a row
   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("back-to-back result beats");

   // a last beat always starts the reduction
   a_last_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_data.last) |=> (busy && state_ff == S_MOD))
      else $error("last beat did not start the lookup");

   // reduced indices stay inside the bitmap
   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WR1 || state_ff == S_RD1) |-> (idx1 <= LAST_ADDR && idx2 <= LAST_ADDR))
      else $error("bitmap index out of range");
`endif

endmodule
